// File: design/vlhe_pkg.sv
// Types, constants and helper functions shared by the variable-length Hamming
// encoder pipeline. No dependencies.
package vlhe_pkg;

	localparam int DATA_W = 57;
	localparam int LEN_W = 6;
	localparam int CW_W = 63;
	localparam int PAR_W = 3;
	localparam int NPAR = 6;
	localparam int MAX_DATA_BITS_DEF = 57;

	typedef struct packed {
		logic [DATA_W-1:0] data_bits;
		logic [LEN_W-1:0] data_len;
	} cmd_t;

	typedef struct packed {
		logic [CW_W-1:0] codeword;
		logic [LEN_W-1:0] code_len;
		logic [PAR_W-1:0] parity_count;
	} result_t;

	// stage 1 -> stage 2: clamped length and masked data
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [LEN_W-1:0] len;
	} prep_t;

	// stage 2 -> stage 3: data-only codeword plus length info
	typedef struct packed {
		logic [CW_W-1:0] cw;
		logic [LEN_W-1:0] code_len;
		logic [PAR_W-1:0] parity_count;
	} scat_t;

	// fewest p >= 1 with 2^p >= m + p + 1
	function automatic logic [PAR_W-1:0] parity_count_f(input logic [LEN_W-1:0] m);
		logic [PAR_W-1:0] p;
		p = PAR_W'(NPAR);
		if (m <= LEN_W'(26)) p = PAR_W'(5);
		if (m <= LEN_W'(11)) p = PAR_W'(4);
		if (m <= LEN_W'(4)) p = PAR_W'(3);
		if (m <= LEN_W'(1)) p = PAR_W'(2);
		if (m == LEN_W'(0)) p = PAR_W'(1);
		return p;
	endfunction

	// data bit j goes to the j-th position that is not a power of two
	function automatic logic [CW_W-1:0] scatter_f(input logic [DATA_W-1:0] d);
		logic [CW_W-1:0] cw;
		int di;
		cw = '0;
		di = 0;
		for (int pos = 1; pos <= CW_W; pos++) begin
			if ((pos & (pos - 1)) != 0) begin
				cw[pos-1] = d[di];
				di++;
			end
		end
		return cw;
	endfunction

	// positions covered by parity bit i, parity position itself excluded
	function automatic logic [CW_W-1:0] cover_mask_f(input int i);
		logic [CW_W-1:0] m;
		m = '0;
		for (int pos = 1; pos <= CW_W; pos++)
			if (((pos >> i) & 1) != 0 && pos != (1 << i))
				m[pos-1] = 1'b1;
		return m;
	endfunction

endpackage

// File: design/variable_length_hamming_encoder.sv
// Variable-length even-parity Hamming encoder, top level.
// Depends on vlhe_pkg, vlhe_prep, vlhe_scatter, vlhe_parity.
//
// Usage:
//   A word is transferred in when start is high at a rising clock edge;
//   busy is always low, so a new word may be offered every cycle.
//   cmd.data_len above MAX_DATA_BITS is clamped, and data bits at or above
//   the effective length are ignored.
//   Each word gives exactly one result, shown on result for one cycle with
//   done high, once the word has passed through all three register stages
//   (the result is registered at the end of the parity stage).
//   Throughput is one word per cycle; the three register stages are
//   clamp/mask, data scatter with parity-count lookup, and parity XOR.
//   The receiver cannot stall: every result must be taken while done is high.
//   Reset (arst_n low) clears all stage valid bits at once; words in flight
//   are dropped and no result appears until a new word is transferred.
module variable_length_hamming_encoder import vlhe_pkg::*; #(
	parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output result_t result
);

	logic vld_s1;
	logic vld_s2;
	prep_t prep_s1;
	scat_t scat_s2;

	assign busy = 1'b0;

	vlhe_prep #(
		.MAX_DATA_BITS(MAX_DATA_BITS)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(start),
		.cmd(cmd),
		.vld_s1(vld_s1),
		.prep_s1(prep_s1)
	);

	vlhe_scatter u_scatter (
		.clk(clk),
		.arst_n(arst_n),
		.vld_s1(vld_s1),
		.prep_s1(prep_s1),
		.vld_s2(vld_s2),
		.scat_s2(scat_s2)
	);

	vlhe_parity u_parity (
		.clk(clk),
		.arst_n(arst_n),
		.vld_s2(vld_s2),
		.scat_s2(scat_s2),
		.vld_s3(done),
		.res_s3(result)
	);

endmodule

// File: design/vlhe_prep.sv
// Stage 1: clamps the data length and clears data bits above it.
// Depends on vlhe_pkg.
module vlhe_prep import vlhe_pkg::*; #(
	parameter int MAX_DATA_BITS = MAX_DATA_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  cmd_t cmd,
	output logic vld_s1,
	output prep_t prep_s1
);

	logic [LEN_W-1:0] len;
	logic [DATA_W-1:0] mask;

	always_comb begin
		len = (cmd.data_len > LEN_W'(MAX_DATA_BITS)) ? LEN_W'(MAX_DATA_BITS) : cmd.data_len;
		for (int j = 0; j < DATA_W; j++)
			mask[j] = (LEN_W'(j) < len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			prep_s1.data <= cmd.data_bits & mask;
			prep_s1.len <= len;
		end
	end

endmodule

// File: design/vlhe_scatter.sv
// Stage 2: places data bits at non-power-of-two positions and sizes the code.
// Depends on vlhe_pkg.
module vlhe_scatter import vlhe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_s1,
	input  prep_t prep_s1,
	output logic vld_s2,
	output scat_t scat_s2
);

	logic [PAR_W-1:0] p;

	assign p = parity_count_f(prep_s1.len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			scat_s2.cw <= scatter_f(prep_s1.data);
			scat_s2.code_len <= prep_s1.len + LEN_W'(p);
			scat_s2.parity_count <= p;
		end
	end

endmodule

// File: design/vlhe_parity.sv
// Stage 3: even parity over each coverage group, inserted at positions 2^i.
// Depends on vlhe_pkg.
module vlhe_parity import vlhe_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic vld_s2,
	input  scat_t scat_s2,
	output logic vld_s3,
	output result_t res_s3
);

	logic [CW_W-1:0] cw;

	// groups beyond the parity count cover only positions above code_len,
	// which hold zero, so their parity comes out zero by itself
	always_comb begin
		cw = scat_s2.cw;
		for (int i = 0; i < NPAR; i++)
			cw[(1 << i) - 1] = ^(scat_s2.cw & cover_mask_f(i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			res_s3.codeword <= cw;
			res_s3.code_len <= scat_s2.code_len;
			res_s3.parity_count <= scat_s2.parity_count;
		end
	end

endmodule
